// ===== hdl/swk_pkg.sv =====
// ----------------------------------------------------------------------------
// swk_pkg
// types and constants shared by the swerve wheel kinematics core
// ----------------------------------------------------------------------------
package swk_pkg;

  localparam int QDEPTH   = 4;
  localparam int SQ_BITS  = 22;
  localparam int NORM_BIT = 41;

  localparam logic [1:0] REG_HALF_LENGTH_X     = 2'd0;
  localparam logic [1:0] REG_HALF_WIDTH_Y      = 2'd1;
  localparam logic [1:0] REG_RECIPROCAL_RADIUS = 2'd2;

  localparam logic [15:0] RST_HALF_LENGTH_X     = 16'd16581;
  localparam logic [15:0] RST_HALF_WIDTH_Y      = 16'd11698;
  localparam logic [15:0] RST_RECIPROCAL_RADIUS = 16'd3413;

  localparam logic signed [34:0] PI_Q30    = 35'sd3373259426;
  localparam logic signed [16:0] ANGLE_MAX = 17'sd12868;
  localparam logic [22:0]        RATE_MAX  = 23'd131071;

  localparam logic [29:0] ATAN_Q30 [24] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158,
    30'd67021686,  30'd33543515,  30'd16775850,  30'd8388437,
    30'd4194282,   30'd2097149,   30'd1048575,   30'd524287,
    30'd262143,    30'd131071,    30'd65535,     30'd32767,
    30'd16383,     30'd8191,      30'd4095,      30'd2047,
    30'd1023,      30'd511,       30'd255,       30'd127
  };

  typedef struct packed {
    logic signed [33:0] x28;
    logic signed [33:0] y28;
    logic [1:0]         idx;
    logic               last;
  } wheel_t;

  typedef struct packed {
    logic signed [33:0] x28;
    logic signed [33:0] y28;
    logic [5:0]         k;
    logic [21:0]        ax;
    logic [21:0]        ay;
    logic               zero;
    logic [1:0]         idx;
    logic               last;
  } s1_t;

  typedef struct packed {
    logic signed [44:0] x;
    logic signed [44:0] y;
    logic [43:0]        sqx;
    logic [43:0]        sqy;
    logic               zero;
    logic [1:0]         idx;
    logic               last;
  } s2_t;

  typedef struct packed {
    logic signed [44:0] x;
    logic signed [44:0] y;
    logic signed [34:0] z;
    logic [43:0]        n;
    logic [24:0]        rem;
    logic [21:0]        root;
    logic               zero;
    logic [1:0]         idx;
    logic               last;
  } it_t;

endpackage

// ===== hdl/swk_front.sv =====
// ----------------------------------------------------------------------------
// swk_front
// takes a chassis command, issues one wheel vector per cycle unless stalled
// ----------------------------------------------------------------------------
module swk_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [15:0]  vel_x_i,
  input  logic signed [15:0]  vel_y_i,
  input  logic signed [15:0]  yaw_rate_i,
  input  logic [15:0]         half_length_x_i,
  input  logic [15:0]         half_width_y_i,
  output logic                push_valid_o,
  output swk_pkg::wheel_t     push_data_o,
  input  logic                push_ready_i
);

  logic               busy_q, busy_d;
  logic [1:0]         w_q, w_d;
  logic signed [15:0] vx_q, vy_q;
  logic signed [32:0] pxw_q, pyw_q;
  logic               push, accept;
  logic signed [33:0] xb, yb, pxe, pye;

  assign push       = busy_q && push_ready_i;
  assign in_ready_o = !busy_q || (push && (w_q == 2'd3));
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    busy_d = busy_q;
    w_d    = w_q;
    if (push) begin
      w_d = w_q + 2'd1;
      if (w_q == 2'd3) begin
        busy_d = 1'b0;
      end
    end
    if (accept) begin
      busy_d = 1'b1;
      w_d    = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      w_q    <= 2'd0;
    end else begin
      busy_q <= busy_d;
      w_q    <= w_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      vx_q  <= vel_x_i;
      vy_q  <= vel_y_i;
      pxw_q <= $signed({1'b0, half_length_x_i}) * yaw_rate_i;
      pyw_q <= $signed({1'b0, half_width_y_i}) * yaw_rate_i;
    end
  end

  always_comb begin
    xb  = {{2{vx_q[15]}}, vx_q, 16'h0000};
    yb  = {{2{vy_q[15]}}, vy_q, 16'h0000};
    pxe = {pxw_q[32], pxw_q};
    pye = {pyw_q[32], pyw_q};
    push_data_o.x28  = w_q[0] ? (xb + pye) : (xb - pye);
    push_data_o.y28  = w_q[1] ? (yb - pxe) : (yb + pxe);
    push_data_o.idx  = w_q;
    push_data_o.last = (w_q == 2'd3);
  end

  assign push_valid_o = busy_q;

endmodule

// ===== hdl/swk_queue.sv =====
// ----------------------------------------------------------------------------
// swk_queue
// short queue of wheel vectors between front and back
// ----------------------------------------------------------------------------
module swk_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  input  swk_pkg::wheel_t push_data_i,
  output logic            push_ready_o,
  output logic            pop_valid_o,
  output swk_pkg::wheel_t pop_data_o,
  input  logic            pop_ready_i
);

  localparam int PW = $clog2(swk_pkg::QDEPTH);

  swk_pkg::wheel_t mem_q [swk_pkg::QDEPTH];
  logic [PW-1:0]   wp_q, rp_q;
  logic [PW:0]     cnt_q;
  logic            push, pop;

  assign push_ready_o = (cnt_q != (PW+1)'(swk_pkg::QDEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rp_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wp_q <= wp_q + 1'b1;
      end
      if (pop) begin
        rp_q <= rp_q + 1'b1;
      end
      cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= push_data_i;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PW+1)'(swk_pkg::QDEPTH))
    else $error("queue count out of range");
`endif

endmodule

// ===== hdl/swk_back.sv =====
// ----------------------------------------------------------------------------
// swk_back
// per wheel angle by cordic and rate by bit serial square root, pipelined
// ----------------------------------------------------------------------------
module swk_back #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               pop_valid_i,
  input  swk_pkg::wheel_t    pop_data_i,
  output logic               pop_ready_o,
  input  logic [15:0]        recip_radius_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         wheel_index_o,
  output logic signed [14:0] steer_angle_o,
  output logic [16:0]        wheel_rate_o,
  output logic               last_o
);

  localparam int NSTG = (CORDIC_STEPS > swk_pkg::SQ_BITS) ? CORDIC_STEPS : swk_pkg::SQ_BITS;

  logic            en;
  logic            v1_q, v2_q, out_valid_q;
  logic [NSTG:0]   vit_q;
  swk_pkg::s1_t    s1_d, s1_q;
  swk_pkg::s2_t    s2_d, s2_q;
  swk_pkg::it_t    it_q [NSTG+1];
  swk_pkg::it_t    it0_d;

  assign en          = !out_valid_q || out_ready_i;
  assign pop_ready_o = en;

  // normalize amount and rounded components
  always_comb begin
    logic [33:0] ax28, ay28, m;
    logic [5:0]  blen;
    logic signed [33:0] xr, yr;
    ax28 = pop_data_i.x28[33] ? 34'(-pop_data_i.x28) : pop_data_i.x28;
    ay28 = pop_data_i.y28[33] ? 34'(-pop_data_i.y28) : pop_data_i.y28;
    m    = ax28 | ay28;
    blen = '0;
    for (int b = 0; b < 34; b++) begin
      if (m[b]) begin
        blen = 6'(b + 1);
      end
    end
    xr = pop_data_i.x28 + 34'sd2048;
    yr = pop_data_i.y28 + 34'sd2048;
    s1_d.x28  = pop_data_i.x28;
    s1_d.y28  = pop_data_i.y28;
    s1_d.k    = 6'(swk_pkg::NORM_BIT) - blen;
    s1_d.ax   = xr[33] ? 22'(-xr[33:12]) : xr[33:12];
    s1_d.ay   = yr[33] ? 22'(-yr[33:12]) : yr[33:12];
    s1_d.zero = (m == '0);
    s1_d.idx  = pop_data_i.idx;
    s1_d.last = pop_data_i.last;
  end

  always_comb begin
    s2_d.x    = $signed({{11{s1_q.x28[33]}}, s1_q.x28}) <<< s1_q.k;
    s2_d.y    = $signed({{11{s1_q.y28[33]}}, s1_q.y28}) <<< s1_q.k;
    s2_d.sqx  = s1_q.ax * s1_q.ax;
    s2_d.sqy  = s1_q.ay * s1_q.ay;
    s2_d.zero = s1_q.zero;
    s2_d.idx  = s1_q.idx;
    s2_d.last = s1_q.last;
  end

  // left half plane pre-rotation by pi
  always_comb begin
    it0_d.x    = s2_q.x;
    it0_d.y    = s2_q.y;
    it0_d.z    = '0;
    if (s2_q.x[44]) begin
      it0_d.x = -s2_q.x;
      it0_d.y = -s2_q.y;
      it0_d.z = s2_q.y[44] ? -swk_pkg::PI_Q30 : swk_pkg::PI_Q30;
    end
    it0_d.n    = s2_q.sqx + s2_q.sqy;
    it0_d.rem  = '0;
    it0_d.root = '0;
    it0_d.zero = s2_q.zero;
    it0_d.idx  = s2_q.idx;
    it0_d.last = s2_q.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      vit_q[0] <= 1'b0;
    end else if (en) begin
      v1_q     <= pop_valid_i;
      v2_q     <= v1_q;
      vit_q[0] <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q     <= s1_d;
      s2_q     <= s2_d;
      it_q[0]  <= it0_d;
    end
  end

  for (genvar g = 0; g < NSTG; g++) begin : g_it
    swk_pkg::it_t nxt;
    always_comb begin
      logic signed [44:0] dx, dy;
      logic [24:0]        t, trial;
      nxt = it_q[g];
      dx  = it_q[g].y >>> g;
      dy  = it_q[g].x >>> g;
      t   = '0;
      trial = '0;
      if (g < CORDIC_STEPS) begin
        if (!it_q[g].y[44]) begin
          nxt.x = it_q[g].x + dx;
          nxt.y = it_q[g].y - dy;
          nxt.z = it_q[g].z + 35'($signed({1'b0, swk_pkg::ATAN_Q30[g]}));
        end else begin
          nxt.x = it_q[g].x - dx;
          nxt.y = it_q[g].y + dy;
          nxt.z = it_q[g].z - 35'($signed({1'b0, swk_pkg::ATAN_Q30[g]}));
        end
      end
      if (g < swk_pkg::SQ_BITS) begin
        t     = {it_q[g].rem[22:0], it_q[g].n[43:42]};
        trial = {1'b0, it_q[g].root, 2'b01};
        nxt.n = {it_q[g].n[41:0], 2'b00};
        if (t >= trial) begin
          nxt.rem  = t - trial;
          nxt.root = {it_q[g].root[20:0], 1'b1};
        end else begin
          nxt.rem  = t;
          nxt.root = {it_q[g].root[20:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vit_q[g+1] <= 1'b0;
      end else if (en) begin
        vit_q[g+1] <= vit_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        it_q[g+1] <= nxt;
      end
    end
  end

  // rounding, clamping and rate scaling
  logic signed [34:0] zs;
  logic signed [16:0] zr;
  logic signed [14:0] ang_d;
  logic [37:0]        prod;
  logic [38:0]        rsum;
  logic [16:0]        rate_d;

  always_comb begin
    zs   = it_q[NSTG].z + 35'sd131072;
    zr   = zs[34:18];
    if (zr > swk_pkg::ANGLE_MAX) begin
      ang_d = 15'(swk_pkg::ANGLE_MAX);
    end else if (zr < -swk_pkg::ANGLE_MAX) begin
      ang_d = 15'(-swk_pkg::ANGLE_MAX);
    end else begin
      ang_d = zr[14:0];
    end
    if (it_q[NSTG].zero) begin
      ang_d = '0;
    end
    prod = it_q[NSTG].root * recip_radius_i;
    rsum = {1'b0, prod} + 39'd32768;
    rate_d = (rsum[38:16] > swk_pkg::RATE_MAX) ? 17'h1ffff : rsum[32:16];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vit_q[NSTG];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      wheel_index_o <= it_q[NSTG].idx;
      last_o        <= it_q[NSTG].last;
      steer_angle_o <= ang_d;
      wheel_rate_o  <= rate_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hdl/swerve_wheel_kinematics_core.sv =====
// ----------------------------------------------------------------------------
// swerve_wheel_kinematics_core
// four wheel swerve inverse kinematics with register port
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid_i/in_ready_o) takes one chassis command word of
//   vel_x, vel_y and yaw_rate. output channel (out_valid_o/out_ready_i)
//   gives four wheel words per command in the order LF, RF, LB, RB, with
//   last_o set on the fourth.
//   throughput: one wheel word per cycle while the receiver is ready; the
//   front issues one wheel vector per cycle into a 4 entry queue while it
//   has room, and takes the next command as it pushes the last vector.
//   a wheel word passes the queue, the s1, s2 and it_q[0] registers, the
//   NSTG = max(CORDIC_STEPS, 22) cordic and square root stages and outputs.
//   a stalled receiver freezes the back pipeline; the queue then fills and
//   the front stops taking commands.
//   reset empties the pipeline and queue and loads the standard chassis
//   geometry. registers: 0 half_length_x, 1 half_width_y, 2 reciprocal
//   radius, at byte addresses 0, 4, 8; write them only while idle.
// ----------------------------------------------------------------------------
module swerve_wheel_kinematics_core #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] vel_x_i,
  input  logic signed [15:0] vel_y_i,
  input  logic signed [15:0] yaw_rate_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         wheel_index_o,
  output logic signed [14:0] steer_angle_o,
  output logic [16:0]        wheel_rate_o,
  output logic               last_o
);

  logic [15:0]     hlx_q, hwy_q, rrad_q;
  logic            wr;
  logic            push_valid, push_ready, pop_valid, pop_ready;
  swk_pkg::wheel_t push_data, pop_data;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hlx_q  <= swk_pkg::RST_HALF_LENGTH_X;
      hwy_q  <= swk_pkg::RST_HALF_WIDTH_Y;
      rrad_q <= swk_pkg::RST_RECIPROCAL_RADIUS;
    end else if (wr) begin
      unique case (paddr[3:2])
        swk_pkg::REG_HALF_LENGTH_X:     hlx_q  <= pwdata[15:0];
        swk_pkg::REG_HALF_WIDTH_Y:      hwy_q  <= pwdata[15:0];
        swk_pkg::REG_RECIPROCAL_RADIUS: rrad_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      swk_pkg::REG_HALF_LENGTH_X:     prdata = {16'h0000, hlx_q};
      swk_pkg::REG_HALF_WIDTH_Y:      prdata = {16'h0000, hwy_q};
      swk_pkg::REG_RECIPROCAL_RADIUS: prdata = {16'h0000, rrad_q};
      default:                        prdata = '0;
    endcase
  end

  swk_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .vel_x_i         (vel_x_i),
    .vel_y_i         (vel_y_i),
    .yaw_rate_i      (yaw_rate_i),
    .half_length_x_i (hlx_q),
    .half_width_y_i  (hwy_q),
    .push_valid_o    (push_valid),
    .push_data_o     (push_data),
    .push_ready_i    (push_ready)
  );

  swk_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_data_i  (push_data),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_data_o   (pop_data),
    .pop_ready_i  (pop_ready)
  );

  swk_back #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pop_valid_i    (pop_valid),
    .pop_data_i     (pop_data),
    .pop_ready_o    (pop_ready),
    .recip_radius_i (rrad_q),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .wheel_index_o  (wheel_index_o),
    .steer_angle_o  (steer_angle_o),
    .wheel_rate_o   (wheel_rate_o),
    .last_o         (last_o)
  );

`ifndef SYNTHESIS
  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == (wheel_index_o == 2'd3)))
    else $error("last flag does not match wheel index");
  a_angle_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (steer_angle_o <= 15'sd12868 && steer_angle_o >= -15'sd12868))
    else $error("steer angle out of range");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("command taken while wheels still pending");
`endif

endmodule
